FILE: design/ppb_pkg.sv
// ----------------------------------------------------------------------------
// Projected point pixel binner package
// Payload types, stage control struct and register map of the binner.
// ----------------------------------------------------------------------------
package ppb_pkg;

   localparam int POS_W      = 32;
   localparam int COEF_W     = 32;
   localparam int OFF_W      = 48;
   localparam int PROD_W     = 64;
   localparam int PAIR_W     = 65;
   localparam int SUM_W      = 66;
   localparam int FRAC_W     = 16;
   localparam int COORD_W    = SUM_W - FRAC_W;
   localparam int IDX_W      = 20;
   localparam int CALC_W     = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_LSB = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [CSR_IDX_W-1:0] REG_COEF_COL_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_COL_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_COL_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_ROW_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_ROW_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_ROW_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_COL = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_ROW = 3'd7;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } ppb_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] pixel_index;
      logic             outside;
   } ppb_rsp_type;

   typedef struct packed {
      logic mul;
      logic pair;
      logic sum;
   } ppb_adv_type;

endpackage

FILE: design/ppb_proj_lane.sv
// ----------------------------------------------------------------------------
// Projection lane
// Three-stage dot product of one point with one coefficient row, minus the
// offset, floored to an integer coordinate: multiply, pair add, final add.
// ----------------------------------------------------------------------------
module ppb_proj_lane (
   input  logic                               clock,
   input  ppb_pkg::ppb_adv_type               adv,
   input  ppb_pkg::ppb_req_type               point,
   input  logic signed [ppb_pkg::COEF_W-1:0]  coef_x,
   input  logic signed [ppb_pkg::COEF_W-1:0]  coef_y,
   input  logic signed [ppb_pkg::COEF_W-1:0]  coef_z,
   input  logic signed [ppb_pkg::OFF_W-1:0]   offset,
   output logic signed [ppb_pkg::COORD_W-1:0] coord
);
   import ppb_pkg::*;

   logic signed [PROD_W-1:0]  prod_x_in, prod_y_in, prod_z_in;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PAIR_W-1:0]  pair_a_in, pair_b_in;
   logic signed [PAIR_W-1:0]  pair_a_ff, pair_b_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [COORD_W-1:0] coord_in, coord_ff;

   assign prod_x_in = PROD_W'(coef_x) * PROD_W'(point.pos_x);
   assign prod_y_in = PROD_W'(coef_y) * PROD_W'(point.pos_y);
   assign prod_z_in = PROD_W'(coef_z) * PROD_W'(point.pos_z);

   assign pair_a_in = PAIR_W'(prod_x_ff) + PAIR_W'(prod_y_ff);
   assign pair_b_in = PAIR_W'(prod_z_ff) - PAIR_W'(offset);

   assign sum_in   = SUM_W'(pair_a_ff) + SUM_W'(pair_b_ff);
   assign coord_in = sum_in[SUM_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (adv.mul) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
      if (adv.pair) begin
         pair_a_ff <= pair_a_in;
         pair_b_ff <= pair_b_in;
      end
      if (adv.sum) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

FILE: design/projected_point_pixel_binner.sv
// ----------------------------------------------------------------------------
// Projected point pixel binner
// Maps a 3D point to a detector pixel index through a programmable
// orthographic projection, flagging points that fall off the frame.
// ----------------------------------------------------------------------------
// Pipeline: four register stages (multiply, pair add, final add and floor,
//   range check and index).
// Throughput: one point per cycle unless the output stalls; every stage holds
//   its item while the stage after it is full and stalled.
// Reset: clears all pipeline valid bits and all configuration registers.
module projected_point_pixel_binner #(
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ppb_pkg::ppb_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ppb_pkg::ppb_rsp_type               rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ppb_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ppb_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ppb_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import ppb_pkg::*;

   localparam int COL_W = $clog2(FRAME_WIDTH + 1);
   localparam int ROW_W = $clog2(FRAME_HEIGHT + 1);

   logic signed [COEF_W-1:0] coef_col_x_ff, coef_col_y_ff, coef_col_z_ff;
   logic signed [COEF_W-1:0] coef_row_x_ff, coef_row_y_ff, coef_row_z_ff;
   logic signed [OFF_W-1:0]  offset_col_ff, offset_row_ff;
   logic                     csr_write;
   logic [CSR_IDX_W-1:0]     csr_index;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic ready1, ready2, ready3, ready4;
   ppb_adv_type adv;

   logic signed [COORD_W-1:0] coord_col, coord_row;
   logic                      col_in_frame, row_in_frame;
   logic [CALC_W-1:0]         idx_full;
   ppb_rsp_type               rsp_in, rsp_ff;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1:CSR_IDX_LSB];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_col_x_ff <= '0;
         coef_col_y_ff <= '0;
         coef_col_z_ff <= '0;
         coef_row_x_ff <= '0;
         coef_row_y_ff <= '0;
         coef_row_z_ff <= '0;
         offset_col_ff <= '0;
         offset_row_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_COEF_COL_X: coef_col_x_ff <= pwdata[COEF_W-1:0];
            REG_COEF_COL_Y: coef_col_y_ff <= pwdata[COEF_W-1:0];
            REG_COEF_COL_Z: coef_col_z_ff <= pwdata[COEF_W-1:0];
            REG_COEF_ROW_X: coef_row_x_ff <= pwdata[COEF_W-1:0];
            REG_COEF_ROW_Y: coef_row_y_ff <= pwdata[COEF_W-1:0];
            REG_COEF_ROW_Z: coef_row_z_ff <= pwdata[COEF_W-1:0];
            REG_OFFSET_COL: offset_col_ff <= pwdata[OFF_W-1:0];
            REG_OFFSET_ROW: offset_row_ff <= pwdata[OFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_COEF_COL_X: prdata = CSR_DATA_W'(coef_col_x_ff);
         REG_COEF_COL_Y: prdata = CSR_DATA_W'(coef_col_y_ff);
         REG_COEF_COL_Z: prdata = CSR_DATA_W'(coef_col_z_ff);
         REG_COEF_ROW_X: prdata = CSR_DATA_W'(coef_row_x_ff);
         REG_COEF_ROW_Y: prdata = CSR_DATA_W'(coef_row_y_ff);
         REG_COEF_ROW_Z: prdata = CSR_DATA_W'(coef_row_z_ff);
         REG_OFFSET_COL: prdata = CSR_DATA_W'(offset_col_ff);
         REG_OFFSET_ROW: prdata = CSR_DATA_W'(offset_row_ff);
         default:        prdata = '0;
      endcase
   end

   // pipeline control
   assign ready4    = !v4_ff || rsp_ready;
   assign ready3    = !v3_ff || ready4;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_ready = ready1;

   assign adv.mul  = ready1 && req_valid;
   assign adv.pair = ready2 && v1_ff;
   assign adv.sum  = ready3 && v2_ff;

   assign v1_in = ready1 ? req_valid : v1_ff;
   assign v2_in = ready2 ? v1_ff     : v2_ff;
   assign v3_in = ready3 ? v2_ff     : v3_ff;
   assign v4_in = ready4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   ppb_proj_lane u_col_lane (
      .clock  (clock),
      .adv    (adv),
      .point  (req_data),
      .coef_x (coef_col_x_ff),
      .coef_y (coef_col_y_ff),
      .coef_z (coef_col_z_ff),
      .offset (offset_col_ff),
      .coord  (coord_col)
   );

   ppb_proj_lane u_row_lane (
      .clock  (clock),
      .adv    (adv),
      .point  (req_data),
      .coef_x (coef_row_x_ff),
      .coef_y (coef_row_y_ff),
      .coef_z (coef_row_z_ff),
      .offset (offset_row_ff),
      .coord  (coord_row)
   );

   // range check and index
   assign col_in_frame = !coord_col[COORD_W-1] &&
                         ($unsigned(coord_col) < COORD_W'(FRAME_WIDTH));
   assign row_in_frame = !coord_row[COORD_W-1] &&
                         ($unsigned(coord_row) < COORD_W'(FRAME_HEIGHT));
   assign idx_full = CALC_W'(coord_col[COL_W-1:0]) +
                     CALC_W'(FRAME_WIDTH) * CALC_W'(coord_row[ROW_W-1:0]);

   always_comb begin
      if (col_in_frame && row_in_frame) begin
         rsp_in.pixel_index = idx_full[IDX_W-1:0];
         rsp_in.outside     = 1'b0;
      end else begin
         rsp_in.pixel_index = '0;
         rsp_in.outside     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4 && v3_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

   a_outside_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outside |-> rsp_data.pixel_index == '0)
      else $error("outside result carries a nonzero pixel index");

   a_transfer_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("input transfer did not enter the multiply stage");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready |-> !req_ready)
      else $error("full stalled pipeline still accepts input");

   a_stage3_holds: assert property (@(posedge clock) disable iff (reset)
      v3_ff && v4_ff && !rsp_ready |=> v3_ff && $stable(coord_col) && $stable(coord_row))
      else $error("stalled coordinate stage changed");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Projected point pixel binner testbench
// Drives 3D points through the binner under changing projection settings and
// compares every pixel index and outside flag against stored expected values or
// a local exact-floor predictor; directed corner points first, then random
// points and settings under three patterns of back-pressure and source gaps.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppb_pkg::*;

   localparam int FRAME_W    = 1024;
   localparam int FRAME_H    = 1024;
   localparam int NUM_REGS   = 1 << CSR_IDX_W;
   localparam int LAT_SLACK  = 8;
   localparam int PHASE_PTS  = 530;

   typedef enum int {CFG_RESET, CFG_IDENT, CFG_SHIFT, CFG_EXTREME} cfg_kind_type;

   typedef struct {
      cfg_kind_type cfg;
      ppb_req_type  pt;
      bit           fixed;
      ppb_rsp_type  rsp;
   } bin_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ppb_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ppb_rsp_type rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   logic [63:0] csr_regs  [NUM_REGS];
   logic [63:0] next_regs [NUM_REGS];
   ppb_rsp_type expected_bins [$];
   int          fault_count = 0;
   int          req_idle_pct = 8;
   int          rsp_idle_pct = 57;

   bin_case_type bin_cases [23] = '{
      '{CFG_RESET,   '{32'sd0, 32'sd0, 32'sd0},                         1'b1, '{20'd0, 1'b0}},
      '{CFG_RESET,   '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},       1'b1, '{20'd0, 1'b0}},
      '{CFG_RESET,   '{32'h80000000, 32'h80000000, 32'h80000000},       1'b1, '{20'd0, 1'b0}},
      '{CFG_RESET,   '{-32'sd1, 32'sd1, 32'h55555555},                  1'b1, '{20'd0, 1'b0}},
      '{CFG_IDENT,   '{32'sd0, 32'sd0, 32'sd0},                         1'b1, '{20'd0, 1'b0}},
      '{CFG_IDENT,   '{32'sd1023, 32'sd1023, 32'sd0},                   1'b1,
                     '{20'd1048575, 1'b0}},
      '{CFG_IDENT,   '{32'sd1023, 32'sd0, -32'sd1},                     1'b1, '{20'd1023, 1'b0}},
      '{CFG_IDENT,   '{32'sd0, 32'sd1023, 32'sd1},                      1'b1,
                     '{20'd1047552, 1'b0}},
      '{CFG_IDENT,   '{32'sd1024, 32'sd0, 32'sd0},                      1'b1, '{20'd0, 1'b1}},
      '{CFG_IDENT,   '{-32'sd1, 32'sd0, 32'sd0},                        1'b1, '{20'd0, 1'b1}},
      '{CFG_IDENT,   '{32'sd0, 32'sd1024, 32'sd0},                      1'b1, '{20'd0, 1'b1}},
      '{CFG_IDENT,   '{32'sd0, -32'sd1, 32'sd0},                        1'b1, '{20'd0, 1'b1}},
      '{CFG_IDENT,   '{32'sd5, 32'sd7, 32'h80000000},                   1'b1, '{20'd7173, 1'b0}},
      '{CFG_IDENT,   '{32'h7fffffff, 32'h7fffffff, 32'sd0},             1'b1, '{20'd0, 1'b1}},
      '{CFG_IDENT,   '{32'h80000000, 32'h80000000, 32'h7fffffff},       1'b1, '{20'd0, 1'b1}},
      '{CFG_SHIFT,   '{32'sd3, 32'sd4, 32'sd5},                         1'b0, '{20'd0, 1'b0}},
      '{CFG_SHIFT,   '{-32'sd7, -32'sd3, 32'sd9},                       1'b0, '{20'd0, 1'b0}},
      '{CFG_SHIFT,   '{32'sd200, 32'sd300, -32'sd400},                  1'b0, '{20'd0, 1'b0}},
      '{CFG_SHIFT,   '{32'sd1, 32'sd1, 32'sd1},                         1'b0, '{20'd0, 1'b0}},
      '{CFG_EXTREME, '{32'sd0, 32'sd0, 32'sd0},                         1'b1, '{20'd0, 1'b1}},
      '{CFG_EXTREME, '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},       1'b0, '{20'd0, 1'b0}},
      '{CFG_EXTREME, '{32'h80000000, 32'h80000000, 32'h80000000},       1'b0, '{20'd0, 1'b0}},
      '{CFG_EXTREME, '{-32'sd1, 32'sd1, 32'sd0},                        1'b0, '{20'd0, 1'b0}}
   };

   projected_point_pixel_binner #(
      .FRAME_WIDTH (FRAME_W),
      .FRAME_HEIGHT(FRAME_H)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] sx32(logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [63:0] sx48(logic [47:0] v);
      return {{16{v[47]}}, v};
   endfunction

   function automatic logic [31:0] corner32();
      logic [31:0] v;
      case ($urandom_range(4))
         0: v = 32'h7fffffff;
         1: v = 32'h80000000;
         2: v = 32'h00000000;
         3: v = 32'hffffffff;
         default: v = 32'h00000001;
      endcase
      return v;
   endfunction

   // exact floor of (w . p - off) / 2^16 for column and row, then range check
   function automatic ppb_rsp_type bin_point(ppb_req_type p);
      logic signed [71:0] px, py, pz;
      logic signed [71:0] cx, cy, cz, rx, ry, rz, oc, orow;
      logic signed [71:0] col_sum, row_sum;
      logic signed [55:0] col, row;
      ppb_rsp_type r;
      px = $signed(p.pos_x);
      py = $signed(p.pos_y);
      pz = $signed(p.pos_z);
      cx = $signed(csr_regs[REG_COEF_COL_X][31:0]);
      cy = $signed(csr_regs[REG_COEF_COL_Y][31:0]);
      cz = $signed(csr_regs[REG_COEF_COL_Z][31:0]);
      rx = $signed(csr_regs[REG_COEF_ROW_X][31:0]);
      ry = $signed(csr_regs[REG_COEF_ROW_Y][31:0]);
      rz = $signed(csr_regs[REG_COEF_ROW_Z][31:0]);
      oc = $signed(csr_regs[REG_OFFSET_COL][47:0]);
      orow = $signed(csr_regs[REG_OFFSET_ROW][47:0]);
      col_sum = cx * px + cy * py + cz * pz - oc;
      row_sum = rx * px + ry * py + rz * pz - orow;
      col = 56'(col_sum >>> FRAC_W);
      row = 56'(row_sum >>> FRAC_W);
      if (col < 0 || col >= FRAME_W || row < 0 || row >= FRAME_H) begin
         r.pixel_index = '0;
         r.outside = 1'b1;
      end else begin
         r.pixel_index = IDX_W'(col + row * FRAME_W);
         r.outside = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: v = int'($urandom_range(600)) - 300;
         6, 7: v = int'($urandom_range(200000)) - 100000;
         8: v = $urandom;
         default: v = corner32();
      endcase
      return v;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_point(input ppb_req_type pt, input bit fixed, input ppb_rsp_type rsp);
      ppb_rsp_type want;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      want = fixed ? rsp : bin_point(pt);
      req_valid <= 1'b1;
      req_data <= pt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_bins.push_back(want);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_bins.size() != 0) @(negedge clock);
      repeat (LAT_SLACK) @(negedge clock);
   endtask

   task automatic load_regs();
      for (int i = 0; i < NUM_REGS; i++) begin
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= CSR_ADDR_W'(i << CSR_IDX_LSB);
         pwdata <= next_regs[i];
         @(negedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         csr_regs[i] = next_regs[i];
         @(negedge clock);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_preset(input cfg_kind_type k);
      foreach (next_regs[i]) next_regs[i] = '0;
      case (k)
         CFG_IDENT: begin
            next_regs[REG_COEF_COL_X] = sx32(32'h00010000);
            next_regs[REG_COEF_ROW_Y] = sx32(32'h00010000);
         end
         CFG_SHIFT: begin
            next_regs[REG_COEF_COL_X] = sx32(32'h00008000);
            next_regs[REG_COEF_COL_Z] = sx32(32'hffff8000);
            next_regs[REG_COEF_ROW_Y] = sx32(32'h00018000);
            next_regs[REG_OFFSET_COL] = sx48(48'hffff_ff9c_1234);
            next_regs[REG_OFFSET_ROW] = sx48(48'h0000_0001_8000);
         end
         CFG_EXTREME: begin
            next_regs[REG_COEF_COL_X] = sx32(32'h7fffffff);
            next_regs[REG_COEF_COL_Y] = sx32(32'h7fffffff);
            next_regs[REG_COEF_COL_Z] = sx32(32'h7fffffff);
            next_regs[REG_COEF_ROW_X] = sx32(32'h80000000);
            next_regs[REG_COEF_ROW_Y] = sx32(32'h80000000);
            next_regs[REG_COEF_ROW_Z] = sx32(32'h80000000);
            next_regs[REG_OFFSET_COL] = sx48(48'h7fff_ffff_ffff);
            next_regs[REG_OFFSET_ROW] = sx48(48'h8000_0000_0000);
         end
         default: ;
      endcase
      load_regs();
   endtask

   // mostly pixel-scale weights with offsets centering the frame
   task automatic pick_regs();
      int style;
      logic [63:0] raw;
      style = $urandom_range(9);
      for (int i = 0; i < NUM_REGS; i++) begin
         raw = {$urandom, $urandom};
         if (i < REG_OFFSET_COL) begin
            case (style)
               0, 1: next_regs[i] = sx32(raw[31:0]);
               2: next_regs[i] = sx32(corner32());
               default: next_regs[i] = sx32(int'($urandom_range(196608)) - 98304);
            endcase
         end else begin
            case (style)
               0, 1: next_regs[i] = sx48(raw[47:0]);
               2: next_regs[i] = sx48($urandom_range(1) ? {1'b0, {47{1'b1}}} :
                                                          {1'b1, {47{1'b0}}});
               default: next_regs[i] = 64'(longint'($urandom_range(39321600))
                                           - 64'sd19660800 - 64'sd33554432);
            endcase
         end
      end
      load_regs();
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin
      ppb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bins.size() == 0) begin
            $error("unexpected result transfer: pixel_index %0d outside %0d",
                   rsp_data.pixel_index, rsp_data.outside);
            fault_count++;
         end else begin
            want = expected_bins.pop_front();
            if (rsp_data.pixel_index !== want.pixel_index) begin
               $error("pixel_index expected %0d actual %0d",
                      want.pixel_index, rsp_data.pixel_index);
               fault_count++;
            end
            if (rsp_data.outside !== want.outside) begin
               $error("outside expected %0d actual %0d", want.outside, rsp_data.outside);
               fault_count++;
            end
         end
      end
   end

   initial begin
      #(10_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      cfg_kind_type cur;
      int           sent;
      int           batch;
      ppb_req_type  pt;
      foreach (csr_regs[i]) csr_regs[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      cur = CFG_RESET;
      foreach (bin_cases[i]) begin
         if (bin_cases[i].cfg != cur) begin
            settle();
            cur = bin_cases[i].cfg;
            set_preset(cur);
         end
         send_point(bin_cases[i].pt, bin_cases[i].fixed, bin_cases[i].rsp);
      end

      for (int ph = 0; ph < 3; ph++) begin
         req_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 57 : 0;
         rsp_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 8 : 0;
         sent = 0;
         while (sent < PHASE_PTS) begin
            settle();
            pick_regs();
            batch = $urandom_range(40, 140);
            if (batch > PHASE_PTS - sent) batch = PHASE_PTS - sent;
            repeat (batch) begin
               pt.pos_x = rand_coord();
               pt.pos_y = rand_coord();
               pt.pos_z = rand_coord();
               send_point(pt, 1'b0, '0);
               sent++;
            end
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
